@@ rtl/tksd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Transfer types, parse phases, key numbers and byte codes of the decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       more_follows;
    } t_in;

    typedef struct packed {
        logic       is_special;
        logic [7:0] raw_byte;
        logic [4:0] special_key;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
    } t_out;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_SS3,
        PH_CSI,
        PH_ONE,
        PH_ONE_MOD,
        PH_ONE_LET,
        PH_TWO,
        PH_NUM,
        PH_TWO_END,
        PH_MOD_TAIL,
        PH_TAIL,
        PH_DOS0,
        PH_DOS224
    } t_phase;

    localparam logic [4:0] KEY_NONE   = 5'd31;
    localparam logic [4:0] KEY_UP     = 5'd0;
    localparam logic [4:0] KEY_DOWN   = 5'd1;
    localparam logic [4:0] KEY_LEFT   = 5'd2;
    localparam logic [4:0] KEY_RIGHT  = 5'd3;
    localparam logic [4:0] KEY_HOME   = 5'd4;
    localparam logic [4:0] KEY_END    = 5'd5;
    localparam logic [4:0] KEY_INSERT = 5'd6;
    localparam logic [4:0] KEY_DELETE = 5'd7;
    localparam logic [4:0] KEY_PGUP   = 5'd8;
    localparam logic [4:0] KEY_PGDN   = 5'd9;
    localparam logic [4:0] KEY_F1     = 5'd10;
    localparam logic [4:0] KEY_LAST   = 5'd21;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_E0    = 8'd224;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam logic [7:0] DOS_F1   = 8'd59;
    localparam logic [7:0] DOS_F10  = 8'd68;
    localparam logic [7:0] DOS_F11  = 8'd133;
    localparam logic [7:0] DOS_F12  = 8'd134;
    localparam logic [7:0] DOS_HOME = 8'd71;
    localparam logic [7:0] DOS_UP   = 8'd72;
    localparam logic [7:0] DOS_PGUP = 8'd73;
    localparam logic [7:0] DOS_LEFT = 8'd75;
    localparam logic [7:0] DOS_RGHT = 8'd77;
    localparam logic [7:0] DOS_END  = 8'd79;
    localparam logic [7:0] DOS_DOWN = 8'd80;
    localparam logic [7:0] DOS_PGDN = 8'd81;
    localparam logic [7:0] DOS_INS  = 8'd82;
    localparam logic [7:0] DOS_DEL  = 8'd83;

endpackage
`default_nettype wire

@@ rtl/tksd_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence parser
// Holds the parse state and decodes one registered byte per step into at
// most one finished key.
// ----------------------------------------------------------------------------
module tksd_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire tksd_pkg::t_in i_in,
    output logic               o_done,
    output tksd_pkg::t_out     o_res
);
    import tksd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [4:0] r_key,   n_key;
    logic [2:0] r_mods,  n_mods;
    logic [7:0] r_prefix, n_prefix;

    logic       w_fin;
    logic       w_imm;
    logic [4:0] w_key;
    logic [7:0] w_raw;
    logic [2:0] w_mods;
    logic [4:0] w_let;
    logic       w_spec;
    logic [7:0] b;

    function automatic logic [2:0] mod_code(input logic [7:0] c);
        logic [2:0] m;
        m = 3'd0;
        if (c >= CH_2 && c <= CH_8) begin
            m = 3'(c - CH_1);
        end
        return m;
    endfunction

    function automatic logic [4:0] csi_letter(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_A:    k = KEY_UP;
            CH_B:    k = KEY_DOWN;
            CH_C:    k = KEY_RIGHT;
            CH_D:    k = KEY_LEFT;
            CH_H:    k = KEY_HOME;
            CH_F:    k = KEY_END;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] two_digit_one(input logic [7:0] c);
        logic [4:0] k;
        k = KEY_NONE;
        if (c >= CH_1 && c <= CH_5) begin
            k = KEY_F1 + 5'(c - CH_1);
        end else if (c >= CH_7 && c <= CH_9) begin
            k = KEY_F1 + 5'd5 + 5'(c - CH_7);
        end
        return k;
    endfunction

    function automatic logic [4:0] two_digit_two(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_0:    k = KEY_F1 + 5'd8;
            CH_1:    k = KEY_F1 + 5'd9;
            CH_3:    k = KEY_F1 + 5'd10;
            CH_4:    k = KEY_F1 + 5'd11;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] dos0_key(input logic [7:0] c);
        logic [4:0] k;
        k = KEY_NONE;
        if (c >= DOS_F1 && c <= DOS_F10) begin
            k = KEY_F1 + 5'(c - DOS_F1);
        end else if (c == DOS_F11) begin
            k = KEY_F1 + 5'd10;
        end else if (c == DOS_F12) begin
            k = KEY_F1 + 5'd11;
        end
        return k;
    endfunction

    function automatic logic [4:0] dos224_key(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            DOS_F12:  k = KEY_F1 + 5'd11;
            DOS_UP:   k = KEY_UP;
            DOS_DOWN: k = KEY_DOWN;
            DOS_LEFT: k = KEY_LEFT;
            DOS_RGHT: k = KEY_RIGHT;
            DOS_INS:  k = KEY_INSERT;
            DOS_DEL:  k = KEY_DELETE;
            DOS_HOME: k = KEY_HOME;
            DOS_END:  k = KEY_END;
            DOS_PGUP: k = KEY_PGUP;
            DOS_PGDN: k = KEY_PGDN;
            default:  k = KEY_NONE;
        endcase
        return k;
    endfunction

    assign b     = i_in.in_byte;
    assign w_let = csi_letter(b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_key    <= 5'd0;
            r_mods   <= 3'd0;
            r_prefix <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_key    <= n_key;
            r_mods   <= n_mods;
            r_prefix <= n_prefix;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_key    = r_key;
        n_mods   = r_mods;
        n_prefix = r_prefix;
        w_fin    = 1'b0;
        w_imm    = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (b == CH_ESC && i_in.more_follows) begin
                    n_phase  = PH_ESC;
                    n_prefix = CH_ESC;
                    n_key    = KEY_NONE;
                    n_mods   = 3'd0;
                end else if (b == CH_NUL) begin
                    n_phase  = PH_DOS0;
                    n_prefix = CH_NUL;
                    n_key    = KEY_NONE;
                    n_mods   = 3'd0;
                end else if (b == CH_E0) begin
                    n_phase  = PH_DOS224;
                    n_prefix = CH_E0;
                    n_key    = KEY_NONE;
                    n_mods   = 3'd0;
                end else begin
                    w_imm = 1'b1;
                end
            end
            PH_ESC: begin
                if (b == CH_O) begin
                    n_phase = PH_SS3;
                end else if (b == CH_LBRK) begin
                    n_phase = PH_CSI;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_SS3: begin
                if (b >= CH_P && b <= CH_S) begin
                    n_key = KEY_F1 + 5'(b - CH_P);
                end
                w_fin = 1'b1;
            end
            PH_CSI: begin
                if (w_let != KEY_NONE) begin
                    n_key = w_let;
                    w_fin = 1'b1;
                end else if (b == CH_1) begin
                    n_phase = PH_ONE;
                end else if (b == CH_2) begin
                    n_phase = PH_TWO;
                end else if (b == CH_3) begin
                    n_key   = KEY_DELETE;
                    n_phase = PH_NUM;
                end else if (b == CH_4) begin
                    n_key   = KEY_END;
                    n_phase = PH_NUM;
                end else if (b == CH_5) begin
                    n_key   = KEY_PGUP;
                    n_phase = PH_NUM;
                end else if (b == CH_6) begin
                    n_key   = KEY_PGDN;
                    n_phase = PH_NUM;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_ONE: begin
                if (b == CH_TILDE) begin
                    n_key = KEY_HOME;
                    w_fin = 1'b1;
                end else if (b == CH_SEMI) begin
                    n_phase = PH_ONE_MOD;
                end else begin
                    n_key   = two_digit_one(b);
                    n_phase = PH_TWO_END;
                end
            end
            PH_ONE_MOD: begin
                n_mods  = mod_code(b);
                n_phase = PH_ONE_LET;
            end
            PH_ONE_LET: begin
                n_key = w_let;
                w_fin = 1'b1;
            end
            PH_TWO: begin
                if (b == CH_TILDE) begin
                    n_key = KEY_INSERT;
                    w_fin = 1'b1;
                end else if (b == CH_SEMI) begin
                    n_key   = KEY_INSERT;
                    n_phase = PH_MOD_TAIL;
                end else begin
                    n_key   = two_digit_two(b);
                    n_phase = PH_TWO_END;
                end
            end
            PH_NUM: begin
                if (b == CH_TILDE) begin
                    w_fin = 1'b1;
                end else if (b == CH_SEMI) begin
                    n_phase = PH_MOD_TAIL;
                end else begin
                    n_key = KEY_NONE;
                    w_fin = 1'b1;
                end
            end
            PH_TWO_END: begin
                if (b == CH_SEMI) begin
                    n_phase = PH_MOD_TAIL;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_MOD_TAIL: begin
                n_mods  = mod_code(b);
                n_phase = PH_TAIL;
            end
            PH_TAIL: begin
                w_fin = 1'b1;
            end
            PH_DOS0: begin
                n_key = dos0_key(b);
                w_fin = 1'b1;
            end
            PH_DOS224: begin
                n_key = dos224_key(b);
                w_fin = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_imm) begin
            w_key  = KEY_NONE;
            w_raw  = b;
            w_mods = 3'd0;
        end else begin
            w_key  = n_key;
            w_raw  = r_prefix;
            w_mods = n_mods;
        end
        if (w_imm || w_fin) begin
            n_phase = PH_IDLE;
        end
    end

    assign w_spec = (w_key <= KEY_LAST);
    assign o_done = w_imm || w_fin;

    always_comb begin
        o_res.is_special  = w_spec;
        o_res.raw_byte    = w_spec ? 8'd0 : w_raw;
        o_res.special_key = w_spec ? w_key : 5'd0;
        o_res.shift_held  = w_mods[0];
        o_res.ctrl_held   = w_mods[2];
        o_res.alt_held    = w_mods[1];
    end

endmodule
`default_nettype wire

@@ rtl/tksd_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result queue; space is reported from registered state only.
// ----------------------------------------------------------------------------
module tksd_obuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tksd_pkg::t_out i_res,
    output logic                o_space,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tksd_pkg::t_out      o_out_data
);
    import tksd_pkg::*;

    t_out       r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       w_pop;
    logic       w_to_head;

    assign w_pop       = (r_cnt != 2'd0) && i_out_ready;
    assign w_to_head   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);
    assign o_space     = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && w_to_head) begin
            r_q0 <= i_res;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
        if (i_push && !w_to_head) begin
            r_q1 <= i_res;
        end
    end

endmodule
`default_nettype wire

@@ rtl/terminal_key_sequence_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Decodes xterm escape sequences and DOS scan code prefixes into keys.
//
//   channel  direction  valid         ready         payload
//   input    in         i_in_valid    o_in_ready    i_in_data  (t_in)
//   result   out        o_out_valid   i_out_ready   o_out_data (t_out)
//
// One byte per cycle sustained while the result queue has space: a byte is
// registered, decoded against the parse state and its key, if any, lands in a
// two-entry result queue. The byte passes the input register and then the
// result queue register before its result is valid.
// Reset clears the parse state, the input valid flag and the queue.
// A stalled result side stops input once the queue holds two keys and a
// byte waits in the input register.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tksd_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tksd_pkg::t_out      o_out_data
);
    import tksd_pkg::*;

    logic r_in_vld;
    t_in  r_in;
    logic w_space;
    logic w_step;
    logic w_done;
    t_out w_res;

    assign w_step     = r_in_vld && w_space;
    assign o_in_ready = !r_in_vld || w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    tksd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_in    (r_in),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    tksd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_step && w_done),
        .i_res       (w_res),
        .o_space     (w_space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Feeds the decoder a byte stream of plain bytes, xterm sequences, DOS scan
// code pairs and broken sequences under random input bursts and output
// stalls. A scoreboard tracks the parse state of every transferred byte,
// queues the key it should complete and checks each result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
    import tksd_pkg::*;

    class key_decode_board;
        t_phase      parse_at;
        logic [4:0]  held_key;
        logic [2:0]  held_mods;
        logic [3:0]  first_digit;
        logic [7:0]  opener;
        t_out        keys_due[$];
        int unsigned bad_keys;
        int unsigned n_bytes;
        int unsigned n_keys;
        int unsigned n_special;
        int unsigned n_mods;

        function new();
            parse_at    = PH_IDLE;
            held_key    = '0;
            held_mods   = '0;
            first_digit = '0;
            opener      = '0;
            bad_keys    = 0;
            n_bytes     = 0;
            n_keys      = 0;
            n_special   = 0;
            n_mods      = 0;
        endfunction

        function int pending();
            return keys_due.size();
        endfunction

        function logic [2:0] modifier_of(logic [7:0] b);
            if (b >= CH_2 && b <= CH_8) begin
                return 3'(b - CH_1);
            end
            return 3'b000;
        endfunction

        function logic [4:0] arrow_of(logic [7:0] b);
            case (b)
                CH_A: return KEY_UP;
                CH_B: return KEY_DOWN;
                CH_C: return KEY_RIGHT;
                CH_D: return KEY_LEFT;
                CH_H: return KEY_HOME;
                CH_F: return KEY_END;
                default: return KEY_NONE;
            endcase
        endfunction

        function logic [4:0] fkey_of(logic [3:0] lead, logic [7:0] b);
            if (lead == 4'd1) begin
                if (b >= CH_1 && b <= CH_5) begin
                    return KEY_F1 + 5'(b - CH_1);
                end
                if (b >= CH_7 && b <= CH_9) begin
                    return KEY_F1 + 5'd5 + 5'(b - CH_7);
                end
                return KEY_NONE;
            end
            case (b)
                CH_0: return KEY_F1 + 5'd8;
                CH_1: return KEY_F1 + 5'd9;
                CH_3: return KEY_F1 + 5'd10;
                CH_4: return KEY_F1 + 5'd11;
                default: return KEY_NONE;
            endcase
        endfunction

        function void push_key(logic [4:0] key, logic [7:0] raw, logic [2:0] mods);
            t_out r;
            logic special;
            special       = (key != KEY_NONE) && (key <= KEY_LAST);
            r.is_special  = special;
            r.raw_byte    = special ? 8'd0 : raw;
            r.special_key = special ? key : 5'd0;
            r.shift_held  = mods[0];
            r.alt_held    = mods[1];
            r.ctrl_held   = mods[2];
            keys_due.push_back(r);
            parse_at = PH_IDLE;
            n_keys++;
            if (special) n_special++;
            if (mods != 3'b000) n_mods++;
        endfunction

        function void open_seq(t_phase ph, logic [7:0] prefix);
            parse_at    = ph;
            opener      = prefix;
            held_key    = KEY_NONE;
            held_mods   = 3'b000;
            first_digit = 4'd0;
        endfunction

        function void take_byte(t_in d);
            logic [7:0] b;
            b = d.in_byte;
            n_bytes++;
            case (parse_at)
                PH_IDLE: begin
                    if (b == CH_ESC) begin
                        if (!d.more_follows) push_key(KEY_NONE, CH_ESC, 3'b000);
                        else open_seq(PH_ESC, CH_ESC);
                    end else if (b == CH_NUL) begin
                        open_seq(PH_DOS0, CH_NUL);
                    end else if (b == CH_E0) begin
                        open_seq(PH_DOS224, CH_E0);
                    end else begin
                        push_key(KEY_NONE, b, 3'b000);
                    end
                end
                PH_ESC: begin
                    if (b == CH_O) parse_at = PH_SS3;
                    else if (b == CH_LBRK) parse_at = PH_CSI;
                    else push_key(held_key, opener, held_mods);
                end
                PH_SS3: begin
                    if (b >= CH_P && b <= CH_S) held_key = KEY_F1 + 5'(b - CH_P);
                    push_key(held_key, opener, held_mods);
                end
                PH_CSI: begin
                    if (arrow_of(b) != KEY_NONE) begin
                        held_key = arrow_of(b);
                        push_key(held_key, opener, held_mods);
                    end else if (b >= CH_1 && b <= CH_6) begin
                        first_digit = 4'(b - CH_0);
                        case (b)
                            CH_1: parse_at = PH_ONE;
                            CH_2: parse_at = PH_TWO;
                            CH_3: begin
                                held_key = KEY_DELETE;
                                parse_at = PH_NUM;
                            end
                            CH_4: begin
                                held_key = KEY_END;
                                parse_at = PH_NUM;
                            end
                            CH_5: begin
                                held_key = KEY_PGUP;
                                parse_at = PH_NUM;
                            end
                            default: begin
                                held_key = KEY_PGDN;
                                parse_at = PH_NUM;
                            end
                        endcase
                    end else begin
                        push_key(held_key, opener, held_mods);
                    end
                end
                PH_ONE: begin
                    if (b == CH_TILDE) begin
                        held_key = KEY_HOME;
                        push_key(held_key, opener, held_mods);
                    end else if (b == CH_SEMI) begin
                        parse_at = PH_ONE_MOD;
                    end else begin
                        held_key = fkey_of(first_digit, b);
                        parse_at = PH_TWO_END;
                    end
                end
                PH_ONE_MOD: begin
                    held_mods = modifier_of(b);
                    parse_at  = PH_ONE_LET;
                end
                PH_ONE_LET: begin
                    held_key = arrow_of(b);
                    push_key(held_key, opener, held_mods);
                end
                PH_TWO: begin
                    if (b == CH_TILDE) begin
                        held_key = KEY_INSERT;
                        push_key(held_key, opener, held_mods);
                    end else if (b == CH_SEMI) begin
                        held_key = KEY_INSERT;
                        parse_at = PH_MOD_TAIL;
                    end else begin
                        held_key = fkey_of(first_digit, b);
                        parse_at = PH_TWO_END;
                    end
                end
                PH_NUM: begin
                    if (b == CH_TILDE) begin
                        push_key(held_key, opener, held_mods);
                    end else if (b == CH_SEMI) begin
                        parse_at = PH_MOD_TAIL;
                    end else begin
                        held_key = KEY_NONE;
                        push_key(held_key, opener, held_mods);
                    end
                end
                PH_TWO_END: begin
                    if (b == CH_SEMI) parse_at = PH_MOD_TAIL;
                    else push_key(held_key, opener, held_mods);
                end
                PH_MOD_TAIL: begin
                    held_mods = modifier_of(b);
                    parse_at  = PH_TAIL;
                end
                PH_TAIL: begin
                    push_key(held_key, opener, held_mods);
                end
                PH_DOS0: begin
                    if (b >= DOS_F1 && b <= DOS_F10) held_key = KEY_F1 + 5'(b - DOS_F1);
                    else if (b == DOS_F11) held_key = KEY_F1 + 5'd10;
                    else if (b == DOS_F12) held_key = KEY_F1 + 5'd11;
                    else held_key = KEY_NONE;
                    push_key(held_key, opener, held_mods);
                end
                PH_DOS224: begin
                    case (b)
                        DOS_F12:  held_key = KEY_F1 + 5'd11;
                        DOS_UP:   held_key = KEY_UP;
                        DOS_DOWN: held_key = KEY_DOWN;
                        DOS_LEFT: held_key = KEY_LEFT;
                        DOS_RGHT: held_key = KEY_RIGHT;
                        DOS_INS:  held_key = KEY_INSERT;
                        DOS_DEL:  held_key = KEY_DELETE;
                        DOS_HOME: held_key = KEY_HOME;
                        DOS_END:  held_key = KEY_END;
                        DOS_PGUP: held_key = KEY_PGUP;
                        DOS_PGDN: held_key = KEY_PGDN;
                        default:  held_key = KEY_NONE;
                    endcase
                    push_key(held_key, opener, held_mods);
                end
                default: parse_at = PH_IDLE;
            endcase
        endfunction

        function void check_key(t_out got);
            t_out want;
            if (keys_due.size() == 0) begin
                bad_keys++;
                if (bad_keys <= 10) begin
                    $display("unexpected key: special=%0d raw=%02h key=%0d s/c/a=%0d%0d%0d",
                             got.is_special, got.raw_byte, got.special_key,
                             got.shift_held, got.ctrl_held, got.alt_held);
                end
                return;
            end
            want = keys_due.pop_front();
            if (got.is_special !== want.is_special || got.raw_byte !== want.raw_byte ||
                got.special_key !== want.special_key || got.shift_held !== want.shift_held ||
                got.ctrl_held !== want.ctrl_held || got.alt_held !== want.alt_held) begin
                bad_keys++;
                if (bad_keys <= 10) begin
                    $display("key mismatch: expected special=%0d raw=%02h key=%0d s/c/a=%0d%0d%0d",
                             want.is_special, want.raw_byte, want.special_key,
                             want.shift_held, want.ctrl_held, want.alt_held);
                    $display("                   got special=%0d raw=%02h key=%0d s/c/a=%0d%0d%0d",
                             got.is_special, got.raw_byte, got.special_key,
                             got.shift_held, got.ctrl_held, got.alt_held);
                end
            end
        endfunction
    endclass

    localparam int RANDOM_BYTES = 1900;
    localparam int QUIET_LIMIT  = 4000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    key_decode_board sb;
    t_in             byte_stream[$];
    int unsigned     quiet_cycles = 0;
    int unsigned     rx_left = 0;
    int unsigned     rx_mode = 0;

    logic [7:0] csi_letters [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
    logic [7:0] e0_codes [11] = '{DOS_F12, DOS_UP, DOS_DOWN, DOS_LEFT, DOS_RGHT, DOS_INS,
                                  DOS_DEL, DOS_HOME, DOS_END, DOS_PGUP, DOS_PGDN};

    terminal_key_sequence_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_mod();
        return ($urandom_range(0, 4) == 0) ? any_byte() : CH_2 + 8'($urandom_range(0, 6));
    endfunction

    function automatic logic [7:0] pick_tail();
        return ($urandom_range(0, 5) == 0) ? any_byte() : CH_TILDE;
    endfunction

    function automatic void put(logic [7:0] b, logic more);
        t_in d;
        d.in_byte      = b;
        d.more_follows = more;
        byte_stream.push_back(d);
    endfunction

    function automatic void put_csi();
        put(CH_ESC, 1'b1);
        put(CH_LBRK, coin());
    endfunction

    function automatic void add_random_sequence();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 15);
        case (kind)
            6: begin
                put(CH_ESC, 1'b1);
                put(CH_O, coin());
                put(($urandom_range(0, 4) == 0) ? any_byte() : CH_P + 8'($urandom_range(0, 3)),
                    coin());
            end
            7: begin
                put_csi();
                put(csi_letters[$urandom_range(0, 5)], coin());
            end
            8: begin
                put_csi();
                put(CH_1 + 8'($urandom_range(0, 5)), coin());
                if (coin()) begin
                    put(CH_TILDE, coin());
                end else begin
                    put(CH_SEMI, coin());
                    put(pick_mod(), coin());
                    put(pick_tail(), coin());
                end
            end
            9: begin
                put_csi();
                put(CH_1, coin());
                put(CH_SEMI, coin());
                put(pick_mod(), coin());
                put(($urandom_range(0, 5) == 0) ? any_byte() : csi_letters[$urandom_range(0, 5)],
                    coin());
            end
            10: begin
                put_csi();
                put(coin() ? CH_1 : CH_2, coin());
                put(CH_0 + 8'($urandom_range(0, 9)), coin());
                if (coin()) begin
                    put(pick_tail(), coin());
                end else begin
                    put(CH_SEMI, coin());
                    put(pick_mod(), coin());
                    put(pick_tail(), coin());
                end
            end
            11: begin
                put(CH_NUL, coin());
                n = $urandom_range(0, 14);
                if (n < 10) put(DOS_F1 + 8'(n), coin());
                else if (n == 10) put(DOS_F11, coin());
                else if (n == 11) put(DOS_F12, coin());
                else put(any_byte(), coin());
            end
            12: begin
                put(CH_E0, coin());
                n = $urandom_range(0, 13);
                put((n < 11) ? e0_codes[n] : any_byte(), coin());
            end
            13: begin
                put(CH_ESC, 1'b1);
                if (coin()) put(CH_LBRK, coin());
                repeat ($urandom_range(1, 3)) put(any_byte(), coin());
            end
            14: begin
                if (coin()) begin
                    put(CH_ESC, 1'b0);
                end else begin
                    put(CH_ESC, 1'b1);
                    put(any_byte(), coin());
                end
            end
            15: begin
                put_csi();
                put(CH_1 + 8'($urandom_range(0, 5)), coin());
                put(CH_SEMI, coin());
                put(any_byte(), coin());
                put(any_byte(), coin());
            end
            default: put(any_byte(), coin());
        endcase
    endfunction

    task automatic send_byte(t_in d);
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 120);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= coin();
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.take_byte(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_key(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int directed_n;
        int drain_mid;
        int idx;
        int burst;
        int gap;

        sb = new();

        put(8'hFF, 1'b0);
        put(CH_ESC, 1'b0);
        put(CH_ESC, 1'b1);
        put(CH_LBRK, 1'b0);
        put(CH_A, 1'b0);
        put(CH_ESC, 1'b1);
        put(CH_O, 1'b1);
        put(CH_S, 1'b0);
        put(CH_ESC, 1'b1);
        put(CH_LBRK, 1'b1);
        put(CH_1, 1'b1);
        put(CH_SEMI, 1'b1);
        put(CH_5, 1'b1);
        put(CH_C, 1'b0);
        put(CH_ESC, 1'b1);
        put(CH_LBRK, 1'b1);
        put(CH_3, 1'b1);
        put(CH_SEMI, 1'b1);
        put(CH_9, 1'b1);
        put(8'h7A, 1'b0);
        put(CH_NUL, 1'b1);
        put(DOS_F11, 1'b0);
        put(CH_E0, 1'b1);
        put(8'h20, 1'b0);
        put(CH_ESC, 1'b1);
        put(CH_LBRK, 1'b1);
        put(8'h5A, 1'b0);
        directed_n = byte_stream.size();
        while (byte_stream.size() < directed_n + RANDOM_BYTES) add_random_sequence();
        drain_mid = directed_n + RANDOM_BYTES / 2;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < byte_stream.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < byte_stream.size()) begin
                if (idx == directed_n || idx == drain_mid) wait_drained();
                send_byte(byte_stream[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d bytes and %0d decoded keys", sb.n_bytes, sb.n_keys);
        $display("  %0d special keys, %0d raw keys, %0d keys with modifiers",
                 sb.n_special, sb.n_keys - sb.n_special, sb.n_mods);
        if (sb.bad_keys == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d key errors, %0d keys still due", sb.bad_keys, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/tksd_pkg.sv
rtl/tksd_parse.sv
rtl/tksd_obuf.sv
rtl/terminal_key_sequence_decoder_unit.sv
bench/testbench.sv
